// ===== rtl/border_shrinking_median_filter_defines.svh =====
// assertion macros for the border-shrinking median filter
// no dependencies; included by the top module, which carries the checks
`ifndef BORDER_SHRINKING_MEDIAN_FILTER_DEFINES_SVH
`define BORDER_SHRINKING_MEDIAN_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define BSMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsmf check failed");
`define BSMF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsmf check failed");
`else
`define BSMF_ASSERT_IMP(lbl, ante, cons)
`define BSMF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/bsmf_pkg.sv =====
// shared types and constants of the border-shrinking median filter
// no dependencies
package bsmf_pkg;

  localparam int DEF_MAX_WINDOW = 7;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // output queue depth, also the credit limit on result words in flight
  localparam int FIFO_DEPTH = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [2:0]  RST_WINDOW_SIZE  = 3'd3;
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic valid;
    logic frame_end;
    logic odd;
  } ctl_t;

  typedef struct packed {
    logic [7:0] filtered;
    logic       frame_end;
  } res_t;

endpackage

// ===== rtl/border_shrinking_median_filter.sv =====
// Border-shrinking median filter. Takes one word per clock (pixel or flush)
// when not stalled and gives one result per clock once primed and not held;
// results trail the stream by hi*width+hi pixels (hi = size-1-size/2), and
// any words after a full frame drain the rest. A result word is offered
// after eleven register stages: a line-store read, a column shift window,
// eight one-bit rank cells and the output queue. The line store is a ring of
// 2**clog2(MAX_WINDOW+1) row rams read once per clock at the current column;
// it needs no clearing, since border masking keeps unwritten samples out of
// every window. The input stalls when the sixteen-entry output queue has no
// credit left, and in a frame shorter than hi*width+hi pixels it also stalls
// once the frame is in, while the stream position runs on alone to the full
// lead.
// Depends on bsmf_pkg, bsmf_line_ram, bsmf_rank_cell, bsmf_out_fifo.
`include "border_shrinking_median_filter_defines.svh"
module border_shrinking_median_filter import bsmf_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [7:0]            pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            filtered,
  output logic                  frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int N    = MAX_WINDOW;
  localparam int NN   = N * N;
  localparam int SB   = $clog2(N + 1);
  localparam int RING = 1 << SB;
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT + N + 1);
  localparam int LW   = $clog2(N * MAX_WIDTH + N + 1);
  localparam int NB   = $clog2(NN + 1);
  localparam int OW   = $clog2(FIFO_DEPTH + 1);

  logic [2:0]  window_size;
  logic [10:0] image_width;
  logic [12:0] image_height;

  logic [SB-1:0] size_eff, lo, hi;
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [LW-1:0] delay;

  always_comb begin
    if (window_size == '0) size_eff = SB'(1);
    else if (32'(window_size) > N) size_eff = SB'(N);
    else size_eff = SB'(window_size);
    if (image_width == '0) w_eff = CW'(1);
    else if (32'(image_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(image_width);
    if (image_height == '0) h_eff = RW'(1);
    else if (32'(image_height) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(image_height);
    lo = size_eff >> 1;
    hi = size_eff - SB'(1) - lo;
    delay = LW'(hi) * LW'(w_eff) + LW'(hi);
  end

  // stream position (runs past the last row while draining) and output position
  logic [RW-1:0] srow, orow;
  logic [CW-1:0] scol, ocol;
  logic [LW-1:0] lead;
  logic [OW-1:0] occ;

  logic accept, complete, catchup, step, real_px, emit, last_out, frame_done;
  logic cfg_wr, cfg_hit, out_take;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && (cfg_index == REG_WINDOW_SIZE ||
                     cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // short frame: the stream walks on alone until it leads the output by delay
  assign catchup    = complete && (lead != delay);
  assign in_ready   = (occ < OW'(FIFO_DEPTH)) && !catchup;
  assign accept     = in_valid && in_ready;
  assign complete   = (srow >= h_eff);
  assign step       = (accept && (complete || action == ACT_PIXEL)) || catchup;
  assign real_px    = accept && !complete && action == ACT_PIXEL;
  assign emit       = accept && (complete || (action == ACT_PIXEL && lead == delay));
  assign last_out   = (({1'b0, ocol} + 1'b1) >= {1'b0, w_eff}) &&
                      (({1'b0, orow} + 1'b1) >= {1'b0, h_eff});
  assign frame_done = emit && last_out;
  assign out_take   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= RST_WINDOW_SIZE;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      srow <= '0;
      scol <= '0;
      orow <= '0;
      ocol <= '0;
      lead <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        REG_WINDOW_SIZE:  window_size  <= cfg_data[2:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        default: ;
      endcase
      srow <= '0;
      scol <= '0;
      orow <= '0;
      ocol <= '0;
      lead <= '0;
    end else if (frame_done) begin
      srow <= '0;
      scol <= '0;
      orow <= '0;
      ocol <= '0;
      lead <= '0;
    end else begin
      if (step) begin
        if (({1'b0, scol} + 1'b1) >= {1'b0, w_eff}) begin
          scol <= '0;
          srow <= srow + 1'b1;
        end else begin
          scol <= scol + 1'b1;
        end
      end
      if ((real_px || catchup) && lead != delay) begin
        lead <= lead + 1'b1;
      end
      if (emit) begin
        if (({1'b0, ocol} + 1'b1) >= {1'b0, w_eff}) begin
          ocol <= '0;
          orow <= orow + 1'b1;
        end else begin
          ocol <= ocol + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OW'(emit) - OW'(out_take);
    end
  end

  // in-image rows and columns of the window, indexed back from the newest
  logic [N-1:0] rowv, colv;
  logic [RW:0]  tr;
  logic [CW:0]  tc;

  always_comb begin
    tr = {1'b0, orow} + (RW+1)'(hi);
    tc = {1'b0, ocol} + (CW+1)'(hi);
    for (int m = 0; m < N; m++) begin
      rowv[m] = (SB'(m) < size_eff) && (tr >= (RW+1)'(m)) &&
                ((tr - (RW+1)'(m)) < {1'b0, h_eff});
      colv[m] = (SB'(m) < size_eff) && (tc >= (CW+1)'(m)) &&
                ((tc - (CW+1)'(m)) < {1'b0, w_eff});
    end
  end

  // line store ring
  logic [7:0] ram_rd [RING];

  for (genvar s = 0; s < RING; s++) begin : g_ring
    bsmf_line_ram #(.DEPTH(MAX_WIDTH), .AW(AW)) u_row (
      .clk   (clk),
      .we    (real_px && srow[SB-1:0] == SB'(s)),
      .waddr (scol[AW-1:0]),
      .wdata (pixel),
      .raddr (scol[AW-1:0]),
      .rdata (ram_rd[s])
    );
  end

  logic          s1_step, s1_emit, s1_fend;
  logic [7:0]    s1_pixel;
  logic [SB-1:0] s1_slot;
  logic [N-1:0]  s1_rowv, s1_colv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_step <= 1'b0;
      s1_emit <= 1'b0;
    end else begin
      s1_step <= step;
      s1_emit <= emit;
    end
    s1_fend  <= last_out;
    s1_pixel <= pixel;
    s1_slot  <= srow[SB-1:0];
    s1_rowv  <= rowv;
    s1_colv  <= colv;
  end

  // column of the newest stream position: the new sample over older rows
  logic [N-1:0][7:0]        col_vals;
  logic [N-1:0][N-1:0][7:0] win;
  logic [NN-1:0]            mask_c;
  logic [NB-1:0]            n_c;

  always_comb begin
    for (int m = 0; m < N; m++) begin
      if (m == 0) col_vals[m] = s1_pixel;
      else col_vals[m] = ram_rd[s1_slot - SB'(m)];
    end
    for (int k = 0; k < N; k++) begin
      for (int m = 0; m < N; m++) begin
        mask_c[k*N + m] = s1_colv[k] && s1_rowv[m];
      end
    end
    n_c = NB'($countones(s1_rowv) * $countones(s1_colv));
  end

  always_ff @(posedge clk) begin
    if (s1_step) begin
      win[0] <= col_vals;
      for (int k = 1; k < N; k++) begin
        win[k] <= win[k-1];
      end
    end
  end

  ctl_t                cctl  [9];
  logic [NN-1:0][7:0]  cvals [9];
  logic [NN-1:0]       cmask [9];
  logic [NB-1:0]       cklo  [9];
  logic [NB-1:0]       ckhi  [9];
  logic [7:0]          cplo  [9];
  logic [7:0]          cphi  [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      cctl[0] <= '0;
    end else begin
      cctl[0] <= '{valid: s1_emit, frame_end: s1_fend, odd: n_c[0]};
    end
    cmask[0] <= mask_c;
    cklo[0]  <= (n_c - NB'(1)) >> 1;
    ckhi[0]  <= n_c >> 1;
  end

  assign cvals[0] = win;
  assign cplo[0]  = '0;
  assign cphi[0]  = '0;

  for (genvar g = 0; g < 8; g++) begin : g_cells
    bsmf_rank_cell #(.N(N), .NB(NB), .BIT(7 - g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (cctl[g]),
      .vals_in  (cvals[g]),
      .mask_in  (cmask[g]),
      .klo_in   (cklo[g]),
      .khi_in   (ckhi[g]),
      .plo_in   (cplo[g]),
      .phi_in   (cphi[g]),
      .ctl_out  (cctl[g+1]),
      .vals_out (cvals[g+1]),
      .mask_out (cmask[g+1]),
      .klo_out  (cklo[g+1]),
      .khi_out  (ckhi[g+1]),
      .plo_out  (cplo[g+1]),
      .phi_out  (cphi[g+1])
    );
  end

  // mean of the middle pair, ties to even
  logic [8:0] pair_sum;
  logic [7:0] half, rounded;
  res_t       fin_word, rd_word;

  always_comb begin
    pair_sum = {1'b0, cplo[8]} + {1'b0, cphi[8]};
    half     = pair_sum[8:1];
    rounded  = half + {7'b0, pair_sum[0] & half[0]};
    fin_word.filtered  = cctl[8].odd ? cphi[8] : rounded;
    fin_word.frame_end = cctl[8].frame_end;
  end

  bsmf_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cctl[8].valid),
    .wr_word  (fin_word),
    .rd_en    (out_ready),
    .rd_valid (out_valid),
    .rd_word  (rd_word)
  );

  assign filtered  = rd_word.filtered;
  assign frame_end = rd_word.frame_end;

  `BSMF_ASSERT_IMP(a_out_has_credit, out_valid, occ != '0)
  `BSMF_ASSERT_NXT(a_emit_counted, emit, occ != '0)
  `BSMF_ASSERT_NXT(a_cfg_restarts, cfg_hit, srow == '0 && orow == '0 && lead == '0)

endmodule

// ===== rtl/bsmf_line_ram.sv =====
// one row of the line store: simple dual-port ram, registered read
// depends on nothing
module bsmf_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bsmf_rank_cell.sv =====
// one bit step of the rank search: settles bit BIT of the two middle values
// uses bsmf_pkg for the control word
module bsmf_rank_cell import bsmf_pkg::*; #(
  parameter int N = DEF_MAX_WINDOW,
  parameter int NB = $clog2(N*N+1),
  parameter int BIT = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  ctl_t                ctl_in,
  input  logic [N*N-1:0][7:0] vals_in,
  input  logic [N*N-1:0]      mask_in,
  input  logic [NB-1:0]       klo_in,
  input  logic [NB-1:0]       khi_in,
  input  logic [7:0]          plo_in,
  input  logic [7:0]          phi_in,
  output ctl_t                ctl_out,
  output logic [N*N-1:0][7:0] vals_out,
  output logic [N*N-1:0]      mask_out,
  output logic [NB-1:0]       klo_out,
  output logic [NB-1:0]       khi_out,
  output logic [7:0]          plo_out,
  output logic [7:0]          phi_out
);

  localparam logic [7:0] LOW_ONES = 8'((1 << BIT) - 1);
  localparam logic [7:0] BIT_ONE  = 8'(1 << BIT);

  logic [N*N-1:0] le_lo, le_hi;
  logic [NB-1:0]  cnt_lo, cnt_hi;
  logic [7:0]     t_lo, t_hi;

  // count samples at or below prefix with this bit clear
  always_comb begin
    t_lo = plo_in | LOW_ONES;
    t_hi = phi_in | LOW_ONES;
    for (int e = 0; e < N*N; e++) begin
      le_lo[e] = mask_in[e] && (vals_in[e] <= t_lo);
      le_hi[e] = mask_in[e] && (vals_in[e] <= t_hi);
    end
    cnt_lo = NB'($countones(le_lo));
    cnt_hi = NB'($countones(le_hi));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    vals_out <= vals_in;
    mask_out <= mask_in;
    klo_out  <= klo_in;
    khi_out  <= khi_in;
    plo_out  <= (cnt_lo > klo_in) ? plo_in : (plo_in | BIT_ONE);
    phi_out  <= (cnt_hi > khi_in) ? phi_in : (phi_in | BIT_ONE);
  end

endmodule

// ===== rtl/bsmf_out_fifo.sv =====
// result queue between the rank chain and the output port
// uses bsmf_pkg for the result word and depth
module bsmf_out_fifo import bsmf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  res_t wr_word,
  input  logic rd_en,
  output logic rd_valid,
  output res_t rd_word
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CNW = $clog2(FIFO_DEPTH + 1);

  res_t           mem [FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CNW-1:0] count;

  assign rd_valid = (count != '0);
  assign rd_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en && rd_valid) begin
        rd_ptr <= (rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNW'(wr_en) - CNW'(rd_en && rd_valid);
    end
  end

endmodule

// ===== bench/border_shrinking_median_filter_test.sv =====
// testbench for the border-shrinking median filter: random frames, sizes and flushes
// checked word by word against a behavioral predictor of the filter
// depends on bsmf_pkg and border_shrinking_median_filter
module border_shrinking_median_filter_test;
  import bsmf_pkg::*;

  localparam int LIMIT = 5000;
  localparam int SETTLE = 40;
  localparam int RANDOM_WORDS = 1470;
  localparam logic [CFG_IDX_W-1:0] REG_UNLISTED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = ACT_PIXEL;
  logic [7:0] pixel = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] filtered;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  border_shrinking_median_filter dut (.*);

  always #5 clk = ~clk;

  // filter model state
  logic [7:0] line_ring [0:8*1024-1];
  int win_size = int'(RST_WINDOW_SIZE);
  int img_w = int'(RST_IMAGE_WIDTH);
  int img_h = int'(RST_IMAGE_HEIGHT);
  int in_row, in_col, out_row, out_col;
  bit frame_done;
  res_t pending_q [$];

  int fails = 0;
  int words_sent = 0;
  int burst_left = 0;
  int hold_cnt = 0;

  function automatic int clamp(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] window_median(int orow, int ocol);
    int vals [49];
    int n, sz, lo, w, h, x, y, v, k, s, q;
    n = 0;
    sz = clamp(win_size, 7);
    lo = sz / 2;
    w = clamp(img_w, 1024);
    h = clamp(img_h, 4096);
    for (int i = 0; i < sz; i++) begin
      x = orow - lo + i;
      if (x < 0 || x >= h) continue;
      for (int j = 0; j < sz; j++) begin
        y = ocol - lo + j;
        if (y < 0 || y >= w) continue;
        vals[n] = line_ring[(x % 8) * 1024 + y];
        n++;
      end
    end
    for (int i = 1; i < n; i++) begin
      v = vals[i];
      k = i - 1;
      while (k >= 0 && vals[k] > v) begin
        vals[k+1] = vals[k];
        k--;
      end
      vals[k+1] = v;
    end
    if (n % 2 == 1) return 8'(vals[n/2]);
    s = vals[n/2-1] + vals[n/2];
    q = s >> 1;
    // halfway case rounds to even
    if ((s & 1) && (q & 1)) q++;
    return 8'(q);
  endfunction

  task automatic emit_median();
    res_t r;
    r.filtered = window_median(out_row, out_col);
    r.frame_end = 1'b0;
    out_col++;
    if (out_col >= clamp(img_w, 1024)) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= clamp(img_h, 4096)) begin
      r.frame_end = 1'b1;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      frame_done = 1;
    end
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic predict_word(logic act, logic [7:0] pix);
    int w, h, sz, hi, p;
    w = clamp(img_w, 1024);
    h = clamp(img_h, 4096);
    sz = clamp(win_size, 7);
    hi = sz - 1 - sz / 2;
    if (in_row >= h) begin
      emit_median();
      return;
    end
    if (act == ACT_FLUSH) return;
    line_ring[(in_row % 8) * 1024 + in_col] = pix;
    p = in_row * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (p >= hi * w + hi) emit_median();
  endtask

  task automatic send_word(logic act, logic [7:0] pix);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    pixel <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(act, pix);
    words_sent++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
    drain_all();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WINDOW_SIZE: win_size = value & 7;
      REG_IMAGE_WIDTH: img_w = value & 11'h7ff;
      REG_IMAGE_HEIGHT: img_h = value & 13'h1fff;
      default: return;
    endcase
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endtask

  task automatic set_geometry(int ws, int wd, int ht);
    cfg_write(REG_WINDOW_SIZE, ws);
    cfg_write(REG_IMAGE_WIDTH, wd);
    cfg_write(REG_IMAGE_HEIGHT, ht);
  endtask

  function automatic logic [7:0] rand_pixel(int mode);
    case (mode)
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(100, 103));
      default: return $urandom_range(0, 1) ? 8'hff : 8'h00;
    endcase
  endfunction

  // feeds one frame; a negative stop_at runs it to its frame end
  task automatic run_frame(int stop_at);
    int sent, mode;
    logic act;
    sent = 0;
    mode = $urandom_range(0, 2);
    frame_done = 0;
    while (!frame_done && sent != stop_at) begin
      if (in_row < clamp(img_h, 4096)) act = ($urandom_range(0, 99) < 8) ? ACT_FLUSH : ACT_PIXEL;
      else act = ($urandom_range(0, 99) < 85) ? ACT_FLUSH : ACT_PIXEL;
      send_word(act, rand_pixel(mode));
      sent++;
    end
  endtask

  task automatic test_reset_defaults();
    run_frame(6);
  endtask

  task automatic test_window_extremes();
    set_geometry(7, 5, 4);
    run_frame(-1);
    set_geometry(0, 3, 2);
    run_frame(-1);
  endtask

  task automatic test_size_extremes();
    set_geometry(1, 2047, 2);
    run_frame(10);
    set_geometry(2, 1024, 0);
    run_frame(5);
    set_geometry(3, 0, 8191);
    run_frame(5);
    cfg_write(REG_IMAGE_HEIGHT, 4096);
    run_frame(5);
  endtask

  task automatic test_unlisted_index();
    set_geometry(3, 4, 3);
    run_frame(5);
    cfg_write(REG_UNLISTED, 13'h1fff);
    run_frame(-1);
  endtask

  task automatic test_backpressure();
    set_geometry(3, 8, 8);
    drain_all();
    hold_cnt = 400;
    run_frame(-1);
  endtask

  task automatic test_random_frames();
    int start;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      set_geometry($urandom_range(0, 7), $urandom_range(0, 12), $urandom_range(0, 9));
      if ($urandom_range(0, 7) == 0) run_frame($urandom_range(1, 30));
      else run_frame(-1);
    end
  endtask

  // receiver: long hold when asked, otherwise a changing stall pattern
  int stall_mode = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result word filtered %0d frame_end %0d", filtered, frame_end);
        fails++;
      end else begin
        exp_r = pending_q.pop_front();
        if (filtered !== exp_r.filtered) begin
          $error("filtered expected %0d actual %0d", exp_r.filtered, filtered);
          fails++;
        end
        if (frame_end !== exp_r.frame_end) begin
          $error("frame_end expected %0d actual %0d", exp_r.frame_end, frame_end);
          fails++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_window_extremes();
    test_size_extremes();
    test_unlisted_index();
    test_backpressure();
    test_random_frames();
    drain_all();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== border_shrinking_median_filter.f =====
+incdir+rtl
rtl/bsmf_pkg.sv
rtl/bsmf_line_ram.sv
rtl/bsmf_rank_cell.sv
rtl/bsmf_out_fifo.sv
rtl/border_shrinking_median_filter.sv
bench/border_shrinking_median_filter_test.sv
